[hw/rtl/lfsf_pkg.sv]
`default_nettype none

package lfsf_pkg;

    // Field widths fixed by the item format
    localparam int SIZE_W     = 11;
    localparam int ROW_W      = 16;
    localparam int CFG_COL_W  = 11;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Square side saturates at the largest value of its field
    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b1;

    // Configuration reset values
    localparam logic [CFG_COL_W-1:0] COLUMN_COUNT_RST = 11'd1024;
    localparam logic [ROW_W-1:0]     ROW_COUNT_RST    = 16'd1;

    // One cell as it leaves the position sequencer
    typedef struct packed {
        logic             cell_free;
        logic             first_row;
        logic             first_col;
        logic             last;
        logic [ROW_W-1:0] row;
    } issue_t;

endpackage

`default_nettype wire

[hw/rtl/lfsf_if.sv]
`default_nettype none

// Cell stream: one grid cell per transaction
interface cell_if;
    logic valid;
    logic ready;
    logic cell_free;

    modport source (output valid, output cell_free, input ready);
    modport sink (input valid, input cell_free, output ready);
endinterface

// Result stream: one transaction per grid
interface result_if #(
    parameter int COL_W = 10
);
    logic                     valid;
    logic                     ready;
    logic [lfsf_pkg::SIZE_W-1:0] best_size;
    logic [lfsf_pkg::ROW_W-1:0]  best_row;
    logic [COL_W-1:0]         best_col;

    modport source (output valid, output best_size, output best_row, output best_col,
                    input ready);
    modport sink (input valid, input best_size, input best_row, input best_col,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/largest_free_square_finder.sv]
`default_nettype none

// Takes one cell per cycle, back to back; the line buffer is read once and written once a cycle.
// Result: the last cell of a grid is registered in the stage register, then loaded into the result register.
// Throughput: one cell per cycle; a grid-ending cell waits only while the last result is unread.
// Reset: after rst_n releases, cells are refused while every line buffer entry is zeroed;
// configuration writes are taken throughout.
module largest_free_square_finder #(
    parameter int MAX_COLUMNS = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lfsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lfsf_pkg::CFG_DATA_W-1:0] cfg_data,
    cell_if.sink                                 cells,
    result_if.source                             results
);

    import lfsf_pkg::*;

    localparam int COL_W = $clog2(MAX_COLUMNS);

    logic              accept;
    logic              stall;
    logic [COL_W-1:0]  rd_addr;
    issue_t            issue;
    logic              clr_we;
    logic [COL_W-1:0]  clr_addr;
    logic              cell_we;
    logic [COL_W-1:0]  cell_waddr;
    logic [SIZE_W-1:0] cell_wdata;
    logic              ram_we;
    logic [COL_W-1:0]  ram_waddr;
    logic [SIZE_W-1:0] ram_wdata;
    logic [SIZE_W-1:0] ram_rdata;

    lfsf_seq #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .COL_W       (COL_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (cells.valid),
        .in_cell_free (cells.cell_free),
        .stall        (stall),
        .in_ready     (cells.ready),
        .accept       (accept),
        .rd_addr      (rd_addr),
        .issue        (issue),
        .clr_we       (clr_we),
        .clr_addr     (clr_addr)
    );

    // Clearing pass owns the write port until it finishes
    assign ram_we    = clr_we || cell_we;
    assign ram_waddr = clr_we ? clr_addr : cell_waddr;
    assign ram_wdata = clr_we ? '0 : cell_wdata;

    lfsf_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_COLUMNS)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    lfsf_cell #(
        .COL_W (COL_W)
    ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .issue     (issue),
        .rd_addr   (rd_addr),
        .rd_data   (ram_rdata),
        .stall     (stall),
        .wr_en     (cell_we),
        .wr_addr   (cell_waddr),
        .wr_data   (cell_wdata),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_size  (results.best_size),
        .out_row   (results.best_row),
        .out_col   (results.best_col)
    );

endmodule

`default_nettype wire

[hw/rtl/lfsf_ram.sv]
`default_nettype none

// Simple dual-port RAM, registered read, old data on a same-address collision
module lfsf_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lfsf_seq.sv]
`default_nettype none

// Configuration registers, line buffer clearing pass and grid position counters
module lfsf_seq #(
    parameter int MAX_COLUMNS = 1024,
    parameter int COL_W       = 10
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [lfsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lfsf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    input  wire logic                             in_cell_free,
    input  wire logic                             stall,
    output logic                                  in_ready,
    output logic                                  accept,
    output logic      [COL_W-1:0]                 rd_addr,
    output lfsf_pkg::issue_t                      issue,
    output logic                                  clr_we,
    output logic      [COL_W-1:0]                 clr_addr
);

    import lfsf_pkg::*;

    localparam int EW = (COL_W + 1 > CFG_COL_W) ? COL_W + 1 : CFG_COL_W;
    localparam logic [EW-1:0]    MAX_COLS_E = EW'(MAX_COLUMNS);
    localparam logic [COL_W-1:0] LAST_ADDR  = COL_W'(MAX_COLUMNS - 1);

    logic [CFG_COL_W-1:0] col_count_reg;
    logic [ROW_W-1:0]     row_count_reg;
    logic                 clearing_reg;
    logic [COL_W-1:0]     clr_addr_reg;
    logic [COL_W-1:0]     col_pos_reg, col_pos_next;
    logic [ROW_W-1:0]     row_pos_reg, row_pos_next;

    logic [EW-1:0]    cols_eff;
    logic [ROW_W:0]   rows_eff;
    logic             col_end;
    logic             row_end;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= COLUMN_COUNT_RST;
            row_count_reg <= ROW_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLUMN_COUNT: col_count_reg <= cfg_data[CFG_COL_W-1:0];
                REG_ROW_COUNT:    row_count_reg <= cfg_data[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    // Zero the line buffer once after reset, one entry a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign clr_we   = clearing_reg;
    assign clr_addr = clr_addr_reg;

    // Effective grid dimensions: zero reads as one, columns saturate
    always_comb
    begin
        if (col_count_reg == '0)
        begin
            cols_eff = EW'(1);
        end
        else if (EW'(col_count_reg) > MAX_COLS_E)
        begin
            cols_eff = MAX_COLS_E;
        end
        else
        begin
            cols_eff = EW'(col_count_reg);
        end
        rows_eff = (row_count_reg == '0) ? (ROW_W + 1)'(1) : {1'b0, row_count_reg};
    end

    assign col_end = (EW'(col_pos_reg) + EW'(1)) >= cols_eff;
    assign row_end = ({1'b0, row_pos_reg} + (ROW_W + 1)'(1)) >= rows_eff;

    // Handshake
    assign in_ready = !clearing_reg && !stall;
    assign accept   = in_valid && in_ready;
    assign rd_addr  = col_pos_reg;

    always_comb
    begin
        issue.cell_free = in_cell_free;
        issue.first_row = (row_pos_reg == '0);
        issue.first_col = (col_pos_reg == '0);
        issue.last      = col_end && row_end;
        issue.row       = row_pos_reg;
    end

    // Raster position advance
    always_comb
    begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (accept)
        begin
            if (col_end)
            begin
                col_pos_next = '0;
                row_pos_next = row_end ? '0 : row_pos_reg + 1'b1;
            end
            else
            begin
                col_pos_next = col_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lfsf_cell.sv]
`default_nettype none

// Square side update, line buffer write-back, running maximum and result register
module lfsf_cell #(
    parameter int COL_W = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire lfsf_pkg::issue_t              issue,
    input  wire logic [COL_W-1:0]              rd_addr,
    input  wire logic [lfsf_pkg::SIZE_W-1:0]   rd_data,
    output logic                               stall,
    output logic                               wr_en,
    output logic      [COL_W-1:0]              wr_addr,
    output logic      [lfsf_pkg::SIZE_W-1:0]   wr_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [lfsf_pkg::SIZE_W-1:0]   out_size,
    output logic      [lfsf_pkg::ROW_W-1:0]    out_row,
    output logic      [COL_W-1:0]              out_col
);

    import lfsf_pkg::*;

    logic              s1_valid_reg;
    issue_t            s1_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              fwd_reg;
    logic [SIZE_W-1:0] fwd_val_reg;
    logic [SIZE_W-1:0] left_reg;
    logic [SIZE_W-1:0] upleft_reg;
    logic [SIZE_W-1:0] max_size_reg, max_size_next;
    logic [ROW_W-1:0]  max_row_reg, max_row_next;
    logic [COL_W-1:0]  max_col_reg, max_col_next;
    logic              out_valid_reg;
    logic [SIZE_W-1:0] out_size_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;

    logic              fire;
    logic [SIZE_W-1:0] up;
    logic [SIZE_W-1:0] left;
    logic [SIZE_W-1:0] diag;
    logic [SIZE_W-1:0] min_lu;
    logic [SIZE_W-1:0] min_all;
    logic [SIZE_W-1:0] side;
    logic              better;

    // A grid-ending cell waits while the previous result is still held
    assign stall = s1_valid_reg && s1_reg.last && out_valid_reg && !out_ready;
    assign fire  = s1_valid_reg && !stall;

    // Neighbours; the up value comes from the write in flight on a collision
    always_comb
    begin
        up      = s1_reg.first_row ? '0 : (fwd_reg ? fwd_val_reg : rd_data);
        left    = s1_reg.first_col ? '0 : left_reg;
        diag    = (s1_reg.first_col || s1_reg.first_row) ? '0 : upleft_reg;
        min_lu  = (up < left) ? up : left;
        min_all = (min_lu < diag) ? min_lu : diag;
        if (!s1_reg.cell_free)
        begin
            side = '0;
        end
        else if (min_all == SIZE_SAT)
        begin
            side = SIZE_SAT;
        end
        else
        begin
            side = min_all + 1'b1;
        end
        better = side > max_size_reg;
    end

    assign wr_en   = fire;
    assign wr_addr = s1_col_reg;
    assign wr_data = side;

    // Running maximum, with strict compare so the first corner keeps a tie
    always_comb
    begin
        max_size_next = max_size_reg;
        max_row_next  = max_row_reg;
        max_col_next  = max_col_reg;
        if (better)
        begin
            max_size_next = side;
            max_row_next  = s1_reg.row;
            max_col_next  = s1_col_reg;
        end
    end

    // Stage register and forwarding flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= fire && (s1_col_reg == rd_addr);
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg      <= issue;
            s1_col_reg  <= rd_addr;
            fwd_val_reg <= side;
        end
    end

    // Neighbour history and maximum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg     <= '0;
            upleft_reg   <= '0;
            max_size_reg <= '0;
            max_row_reg  <= '0;
            max_col_reg  <= '0;
        end
        else if (fire)
        begin
            left_reg   <= side;
            upleft_reg <= up;
            if (s1_reg.last)
            begin
                max_size_reg <= '0;
                max_row_reg  <= '0;
                max_col_reg  <= '0;
            end
            else
            begin
                max_size_reg <= max_size_next;
                max_row_reg  <= max_row_next;
                max_col_reg  <= max_col_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && s1_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && s1_reg.last)
        begin
            out_size_reg <= max_size_next;
            out_row_reg  <= max_row_next;
            out_col_reg  <= max_col_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_size  = out_size_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;

endmodule

`default_nettype wire
